>>> rtl/apr_pkg.sv
package apr_pkg;

    // Nibble codes of the path encoding
    localparam logic [3:0] CODE_END      = 4'h0;
    localparam logic [3:0] CODE_LAST_IMM = 4'hA;
    localparam logic [3:0] CODE_PREFIX   = 4'hB;
    localparam logic [3:0] CODE_MULTI1   = 4'hC;

    // Value limits used by the encoder and by the stray-zero skip
    localparam logic [31:0] SMALL_LIMIT = 32'd4096;
    localparam logic [31:0] BYTE_MAX    = 32'h0000_00FF;
    localparam logic [31:0] SKIP_HI     = 32'h0000_0FFF;
    localparam logic [31:0] HALF_MAX    = 32'h0000_FFFF;
    localparam logic [31:0] TRIPLE_MAX  = 32'h00FF_FFFF;

    // Depth of the element queue between decoder and encoder
    localparam int QUEUE_DEPTH = 4;

    // One queue entry: a path element, or the end-of-path marker
    typedef struct packed {
        logic        is_end;
        logic        err;
        logic        keep;
        logic [31:0] value;
    } elem_t;

endpackage

>>> rtl/apr_front.sv
module apr_front #(
    parameter int PATH_BYTES   = 12,
    parameter int MAX_ELEMENTS = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_path_byte,
    input  logic          s_path_last,
    input  logic          s_keep_last_element,
    output logic          q_valid,
    output apr_pkg::elem_t q_data,
    input  logic          q_ready
);

    localparam int IW = (PATH_BYTES > 1) ? $clog2(PATH_BYTES) : 1;
    localparam int CW = $clog2(PATH_BYTES + 1);
    localparam int PW = $clog2(PATH_BYTES + 6);
    localparam int NW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [PW-1:0] P_BYTES = PW'(PATH_BYTES);
    localparam logic [NW-1:0] N_MAX   = NW'(MAX_ELEMENTS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NIB   = 4'd1;
    localparam logic [3:0] S_EVAL  = 4'd2;
    localparam logic [3:0] S_PFX   = 4'd3;
    localparam logic [3:0] S_MULTI = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_PUSH  = 4'd6;
    localparam logic [3:0] S_SKIP  = 4'd7;
    localparam logic [3:0] S_SKIP2 = 4'd8;
    localparam logic [3:0] S_END   = 4'd9;

    logic [7:0]    byte_mem_reg [PATH_BYTES];
    logic [CW-1:0] load_count_reg, load_count_next;
    logic [3:0]    state_reg, state_next;
    logic [PW-1:0] p_reg, p_next;
    logic [NW-1:0] n_reg, n_next;
    logic [3:0]    nib_reg, nib_next;
    logic          second_reg, second_next;
    logic [2:0]    nbytes_reg, nbytes_next;
    logic [1:0]    idx_reg, idx_next;
    logic [31:0]   value_reg, value_next;
    logic          keep_reg, keep_next;
    logic          err_reg, err_next;

    logic [PW-1:0] rd_idx;
    logic [7:0]    rd_byte;
    logic          load_en;

    assign s_ready = (state_reg == S_IDLE);
    assign load_en = s_valid && s_ready && (load_count_reg < CW'(PATH_BYTES));

    // Byte store read; bytes beyond the fill count read as zero
    always_comb begin
        unique case (state_reg)
            S_ACC:   rd_idx = p_reg + PW'(idx_reg);
            S_SKIP2: rd_idx = p_reg + PW'(1);
            default: rd_idx = p_reg;
        endcase
        if (rd_idx < PW'(load_count_reg)) begin
            rd_byte = byte_mem_reg[rd_idx[IW-1:0]];
        end else begin
            rd_byte = 8'h00;
        end
    end

    // Decode sequencer
    always_comb begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        p_next          = p_reg;
        n_next          = n_reg;
        nib_next        = nib_reg;
        second_next     = second_reg;
        nbytes_next     = nbytes_reg;
        idx_next        = idx_reg;
        value_next      = value_reg;
        keep_next       = keep_reg;
        err_next        = err_reg;
        q_valid         = 1'b0;
        q_data          = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (load_en) begin
                    load_count_next = load_count_reg + CW'(1);
                end
                if (s_valid && s_path_last) begin
                    keep_next  = s_keep_last_element;
                    p_next     = '0;
                    n_next     = '0;
                    err_next   = 1'b0;
                    state_next = S_NIB;
                end
            end
            S_NIB: begin
                if (p_reg >= P_BYTES) begin
                    state_next = S_END;
                end else begin
                    nib_next    = rd_byte[7:4];
                    second_next = 1'b0;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (nib_reg == apr_pkg::CODE_END) begin
                    state_next = S_END;
                end else if (nib_reg <= apr_pkg::CODE_LAST_IMM) begin
                    if (n_reg >= N_MAX) begin
                        state_next = S_END;
                    end else begin
                        q_valid       = 1'b1;
                        q_data.value  = {28'd0, nib_reg};
                        if (q_ready) begin
                            n_next = n_reg + NW'(1);
                            if (!second_reg) begin
                                nib_next    = rd_byte[3:0];
                                second_next = 1'b1;
                            end else begin
                                p_next     = p_reg + PW'(1);
                                state_next = S_NIB;
                            end
                        end
                    end
                end else if (nib_reg == apr_pkg::CODE_PREFIX) begin
                    if (!second_reg) begin
                        nib_next = rd_byte[3:0];
                        if (rd_byte[3:0] < apr_pkg::CODE_MULTI1) begin
                            err_next   = 1'b1;
                            state_next = S_END;
                        end else begin
                            state_next = S_MULTI;
                        end
                    end else begin
                        p_next = p_reg + PW'(1);
                        if (p_reg + PW'(1) >= P_BYTES) begin
                            state_next = S_END;
                        end else begin
                            state_next = S_PFX;
                        end
                    end
                end else begin
                    state_next = S_MULTI;
                end
            end
            S_PFX: begin
                nib_next = rd_byte[7:4];
                if (rd_byte[7:4] < apr_pkg::CODE_MULTI1) begin
                    err_next   = 1'b1;
                    state_next = S_END;
                end else begin
                    state_next = S_MULTI;
                end
            end
            S_MULTI: begin
                nbytes_next = {1'b0, nib_reg[1:0]} + 3'd1;
                value_next  = second_reg ? 32'd0 : {28'd0, rd_byte[3:0]};
                p_next      = p_reg + PW'(1);
                idx_next    = nib_reg[1:0];
                if (p_reg + PW'(1) + PW'(nib_reg[1:0]) + PW'(1) > P_BYTES) begin
                    state_next = S_END;
                end else begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                value_next = {value_reg[23:0], 8'h00} + {24'd0, rd_byte};
                if (idx_reg == 2'd0) begin
                    state_next = S_PUSH;
                end else begin
                    idx_next = idx_reg - 2'd1;
                end
            end
            S_PUSH: begin
                if (n_reg >= N_MAX) begin
                    state_next = S_END;
                end else begin
                    q_valid      = 1'b1;
                    q_data.value = value_reg;
                    if (q_ready) begin
                        n_next     = n_reg + NW'(1);
                        p_next     = p_reg + PW'(nbytes_reg);
                        state_next = S_SKIP;
                    end
                end
            end
            S_SKIP: begin
                // stray zero after a value in 0x100..0xFFF
                if (value_reg > apr_pkg::BYTE_MAX && value_reg <= apr_pkg::SKIP_HI &&
                    p_reg + PW'(1) < P_BYTES && rd_byte == 8'h00) begin
                    state_next = S_SKIP2;
                end else begin
                    state_next = S_NIB;
                end
            end
            S_SKIP2: begin
                if (rd_byte != 8'h00) begin
                    p_next = p_reg + PW'(1);
                end
                state_next = S_NIB;
            end
            S_END: begin
                q_valid       = 1'b1;
                q_data.is_end = 1'b1;
                q_data.err    = err_reg;
                q_data.keep   = keep_reg;
                if (q_ready) begin
                    load_count_next = '0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            load_count_reg <= '0;
        end else begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
        end
        p_reg      <= p_next;
        n_reg      <= n_next;
        nib_reg    <= nib_next;
        second_reg <= second_next;
        nbytes_reg <= nbytes_next;
        idx_reg    <= idx_next;
        value_reg  <= value_next;
        keep_reg   <= keep_next;
        err_reg    <= err_next;
        if (load_en) begin
            byte_mem_reg[load_count_reg[IW-1:0]] <= s_path_byte;
        end
    end

endmodule

>>> rtl/apr_queue.sv
module apr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  apr_pkg::elem_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output apr_pkg::elem_t out_data
);

    localparam int AW = $clog2(apr_pkg::QUEUE_DEPTH);

    apr_pkg::elem_t mem_reg [apr_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]    count_reg;
    logic           push, pop;

    assign in_ready  = (count_reg != (AW+1)'(apr_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Element queue pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> rtl/apr_back.sv
module apr_back #(
    parameter int PATH_BYTES = 12
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  apr_pkg::elem_t q_data,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_out_last,
    output logic           m_status
);

    localparam int IW = (PATH_BYTES > 1) ? $clog2(PATH_BYTES) : 1;
    localparam int QW = $clog2(PATH_BYTES + 2);
    localparam logic [QW-1:0] Q_BYTES = QW'(PATH_BYTES);

    localparam logic [2:0] B_POP   = 3'd0;
    localparam logic [2:0] B_START = 3'd1;
    localparam logic [2:0] B_MID   = 3'd2;
    localparam logic [2:0] B_BYTES = 3'd3;
    localparam logic [2:0] B_EMIT  = 3'd4;

    logic [7:0]    ob_reg  [PATH_BYTES];
    logic [7:0]    ob_next [PATH_BYTES];
    logic [2:0]    state_reg, state_next;
    logic [QW-1:0] q_reg, q_next;
    logic [31:0]   id_reg, id_next;
    logic [2:0]    len_reg, len_next;
    logic [31:0]   pend_reg, pend_next;
    logic          has_pend_reg, has_pend_next;
    logic          emit_after_reg, emit_after_next;
    logic          err_reg, err_next;
    logic [IW-1:0] k_reg, k_next;

    logic [7:0]    cur_byte;
    logic [3:0]    put_val;
    logic [2:0]    len_calc;
    logic [2:0]    done_state;

    assign q_ready    = (state_reg == B_POP);
    assign m_valid    = (state_reg == B_EMIT);
    assign m_out_byte = err_reg ? 8'h00 : ob_reg[k_reg];
    assign m_out_last = (k_reg == IW'(PATH_BYTES - 1));
    assign m_status   = err_reg;

    assign cur_byte   = (q_reg < Q_BYTES) ? ob_reg[q_reg[IW-1:0]] : 8'h00;
    assign done_state = emit_after_reg ? B_EMIT : B_POP;

    // Byte length of a multi-byte value
    always_comb begin
        if (id_reg <= apr_pkg::BYTE_MAX) begin
            len_calc = 3'd1;
        end else if (id_reg <= apr_pkg::HALF_MAX) begin
            len_calc = 3'd2;
        end else if (id_reg <= apr_pkg::TRIPLE_MAX) begin
            len_calc = 3'd3;
        end else begin
            len_calc = 3'd4;
        end
    end

    // Encoder sequencer and output buffer updates
    always_comb begin
        ob_next         = ob_reg;
        state_next      = state_reg;
        q_next          = q_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        pend_next       = pend_reg;
        has_pend_next   = has_pend_reg;
        emit_after_next = emit_after_reg;
        err_next        = err_reg;
        k_next          = k_reg;
        put_val         = '0;

        unique case (state_reg)
            B_POP: begin
                // last element is held back until the end marker says whether to keep it
                if (q_valid) begin
                    if (q_data.is_end) begin
                        err_next = q_data.err;
                        k_next   = '0;
                        if (!q_data.err && q_data.keep && has_pend_reg) begin
                            id_next         = pend_reg;
                            emit_after_next = 1'b1;
                            state_next      = B_START;
                        end else begin
                            state_next = B_EMIT;
                        end
                    end else begin
                        pend_next     = q_data.value;
                        has_pend_next = 1'b1;
                        if (has_pend_reg) begin
                            id_next         = pend_reg;
                            emit_after_next = 1'b0;
                            state_next      = B_START;
                        end
                    end
                end
            end
            B_START: begin
                if (q_reg >= Q_BYTES) begin
                    q_next     = Q_BYTES + QW'(1);
                    state_next = done_state;
                end else begin
                    if (id_reg != 32'd0 && id_reg <= 32'(apr_pkg::CODE_LAST_IMM)) begin
                        put_val    = id_reg[3:0];
                        state_next = done_state;
                    end else begin
                        put_val    = apr_pkg::CODE_MULTI1 + {1'b0, len_calc} - 4'd1;
                        len_next   = len_calc;
                        state_next = B_MID;
                    end
                    // place one nibble
                    if (cur_byte != 8'h00) begin
                        ob_next[q_reg[IW-1:0]] = cur_byte | {4'h0, put_val};
                        q_next = q_reg + QW'(1);
                    end else begin
                        ob_next[q_reg[IW-1:0]] = {put_val, 4'h0};
                    end
                end
            end
            B_MID: begin
                // a half-used byte takes a 12-bit value with the length code
                if (q_reg < Q_BYTES && cur_byte != 8'h00) begin
                    if (id_reg < apr_pkg::SMALL_LIMIT) begin
                        ob_next[q_reg[IW-1:0]] = {apr_pkg::CODE_MULTI1, id_reg[11:8]};
                        len_next = 3'd1;
                        id_next  = {24'd0, id_reg[7:0]};
                    end
                    q_next = q_reg + QW'(1);
                end
                state_next = B_BYTES;
            end
            B_BYTES: begin
                if (len_reg == 3'd0) begin
                    state_next = done_state;
                end else if (q_reg >= Q_BYTES) begin
                    q_next     = q_reg + QW'(1);
                    state_next = done_state;
                end else begin
                    ob_next[q_reg[IW-1:0]] = id_reg[7:0];
                    q_next   = q_reg + QW'(1);
                    id_next  = {8'h00, id_reg[31:8]};
                    len_next = len_reg - 3'd1;
                end
            end
            B_EMIT: begin
                if (m_ready) begin
                    if (m_out_last) begin
                        for (int i = 0; i < PATH_BYTES; i++) begin
                            ob_next[i] = 8'h00;
                        end
                        q_next        = '0;
                        has_pend_next = 1'b0;
                        state_next    = B_POP;
                    end else begin
                        k_next = k_reg + IW'(1);
                    end
                end
            end
            default: begin
                state_next = B_POP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_POP;
            q_reg        <= '0;
            has_pend_reg <= 1'b0;
            err_reg      <= 1'b0;
            k_reg        <= '0;
            for (int i = 0; i < PATH_BYTES; i++) begin
                ob_reg[i] <= 8'h00;
            end
        end else begin
            state_reg    <= state_next;
            q_reg        <= q_next;
            has_pend_reg <= has_pend_next;
            err_reg      <= err_next;
            k_reg        <= k_next;
            ob_reg       <= ob_next;
        end
        id_reg         <= id_next;
        len_reg        <= len_next;
        pend_reg       <= pend_next;
        emit_after_reg <= emit_after_next;
    end

endmodule

>>> rtl/activity_path_reencoder.sv
// Channel  Direction  Transfer contents
// s_       in         one encoded path byte, last mark, keep-last flag
// m_       out        one re-encoded byte, last mark, status
//
// Bytes are taken one per cycle until the last-marked byte. The decoder then
// walks the stored bytes, feeding a four-entry element queue; the encoder
// packs each element into the output buffer, and the PATH_BYTES result bytes
// leave one per cycle while m_ready is high.
// Reset is synchronous and active low; a stalled m_ side holds the encoder,
// and the queue lets the decoder run ahead until it fills.
module activity_path_reencoder #(
    parameter int PATH_BYTES   = 12,
    parameter int MAX_ELEMENTS = 24
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_path_byte,
    input  logic       s_path_last,
    input  logic       s_keep_last_element,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last,
    output logic       m_status
);

    logic           fq_valid, fq_ready, bq_valid, bq_ready;
    apr_pkg::elem_t fq_data, bq_data;

    // Loader and decoder
    apr_front #(
        .PATH_BYTES   (PATH_BYTES),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_path_byte         (s_path_byte),
        .s_path_last         (s_path_last),
        .s_keep_last_element (s_keep_last_element),
        .q_valid             (fq_valid),
        .q_data              (fq_data),
        .q_ready             (fq_ready)
    );

    // Element queue
    apr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    // Encoder and byte emitter
    apr_back #(
        .PATH_BYTES (PATH_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (bq_valid),
        .q_ready    (bq_ready),
        .q_data     (bq_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last),
        .m_status   (m_status)
    );

endmodule

>>> sim/tb_activity_path_reencoder.sv
`timescale 1ns / 1ps

module tb_activity_path_reencoder;

    localparam int NBYTES    = 12;
    localparam int NELEM     = 24;
    localparam int CYC_LIMIT = 400000;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       status;
    } out_beat_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_path_byte;
    logic       s_path_last;
    logic       s_keep_last_element;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_out_last;
    logic       m_status;

    activity_path_reencoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_path_byte(s_path_byte),
        .s_path_last(s_path_last), .s_keep_last_element(s_keep_last_element),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_byte(m_out_byte),
        .m_out_last(m_out_last), .m_status(m_status)
    );

    // Predictor state
    logic [7:0]  load_buf [NBYTES];
    int          load_cnt;
    logic [31:0] elems [NELEM];
    logic [7:0]  enc_buf [NBYTES];

    out_beat_t   pending_beats[$];
    int          errors;
    int          paths_sent;
    int          bytes_sent;
    int          err_paths;
    int          beats_seen;
    int          cycles;
    int          src_idle_pct;
    int          snk_idle_pct;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Walk the nibble-coded path; returns 1 on undefined prefix
    function automatic bit decode_path(output int n);
        int p;
        int nb;
        bit stop;
        bit second;
        bit inner;
        bit err;
        logic [3:0]  nib;
        logic [31:0] val;
        p = 0; n = 0; stop = 0; err = 0;
        while (p < NBYTES && !stop) begin
            nib = load_buf[p][7:4];
            second = 0;
            inner = 1;
            while (inner && !stop) begin
                if (nib == apr_pkg::CODE_END) begin
                    stop = 1;
                end else if (nib <= apr_pkg::CODE_LAST_IMM) begin
                    if (n >= NELEM) begin
                        stop = 1;
                    end else begin
                        elems[n] = 32'(nib);
                        n++;
                        if (!second) begin
                            nib = load_buf[p][3:0];
                            second = 1;
                        end else begin
                            p++;
                            inner = 0;
                        end
                    end
                end else begin
                    if (nib == apr_pkg::CODE_PREFIX) begin
                        if (!second) begin
                            nib = load_buf[p][3:0];
                        end else begin
                            p++;
                            if (p >= NBYTES) stop = 1;
                            else nib = load_buf[p][7:4];
                        end
                        if (!stop && nib < apr_pkg::CODE_MULTI1) begin
                            err = 1;
                            stop = 1;
                        end
                    end
                    if (!stop) begin
                        nb = int'(nib) - int'(apr_pkg::CODE_MULTI1) + 1;
                        val = second ? 32'd0 : 32'(load_buf[p][3:0]);
                        p++;
                        if (p + nb > NBYTES) begin
                            stop = 1;
                        end else begin
                            for (int i = nb - 1; i >= 0; i--)
                                val = (val << 8) + 32'(load_buf[p + i]);
                            if (n >= NELEM) begin
                                stop = 1;
                            end else begin
                                elems[n] = val;
                                n++;
                                p += nb;
                                // stray zero from the old encoder
                                if (val > apr_pkg::BYTE_MAX && val <= apr_pkg::SKIP_HI &&
                                    p + 1 < NBYTES &&
                                    load_buf[p] == 8'h00 && load_buf[p + 1] != 8'h00)
                                    p++;
                                inner = 0;
                            end
                        end
                    end
                end
            end
        end
        return err;
    endfunction

    function automatic void put_nib(ref int q, input logic [3:0] v);
        if (enc_buf[q] != 8'h00) begin
            enc_buf[q] = enc_buf[q] | 8'(v);
            q++;
        end else begin
            enc_buf[q] = {v, 4'h0};
        end
    endfunction

    // Append one element in compact form; returns the new offset
    function automatic int pack_element(input int pos, input logic [31:0] id);
        int q;
        int len;
        q = pos;
        if (q >= NBYTES) return NBYTES + 1;
        if (id > 0 && id <= 32'(apr_pkg::CODE_LAST_IMM)) begin
            put_nib(q, id[3:0]);
            return q;
        end
        len = 4;
        if (id <= apr_pkg::BYTE_MAX) len = 1;
        else if (id <= apr_pkg::HALF_MAX) len = 2;
        else if (id <= apr_pkg::TRIPLE_MAX) len = 3;
        put_nib(q, apr_pkg::CODE_MULTI1 + 4'(len - 1));
        if (q < NBYTES && enc_buf[q] != 8'h00) begin
            if (id < apr_pkg::SMALL_LIMIT) begin
                enc_buf[q] = {apr_pkg::CODE_MULTI1, 4'h0} + 8'(id >> 8);
                len = 1;
                id = id & apr_pkg::BYTE_MAX;
            end
            q++;
        end
        while (len > 0) begin
            if (q >= NBYTES) begin
                q++;
                break;
            end
            enc_buf[q] = id[7:0];
            q++;
            id = id >> 8;
            len--;
        end
        return q;
    endfunction

    // Load one byte; on the last mark queue the twelve re-encoded bytes
    function automatic void predict_byte(logic [7:0] b, logic last, logic keep);
        int n;
        int pos;
        bit err;
        out_beat_t ob;
        if (load_cnt < NBYTES) begin
            load_buf[load_cnt] = b;
            load_cnt++;
        end
        if (!last) return;
        foreach (enc_buf[k]) enc_buf[k] = 8'h00;
        err = decode_path(n);
        if (!err) begin
            if (!keep && n > 0) n--;
            pos = 0;
            for (int i = 0; i < n; i++) pos = pack_element(pos, elems[i]);
        end else begin
            err_paths++;
        end
        for (int k = 0; k < NBYTES; k++) begin
            ob.data   = err ? 8'h00 : enc_buf[k];
            ob.last   = (k == NBYTES - 1);
            ob.status = err;
            pending_beats.push_back(ob);
        end
        foreach (load_buf[k]) load_buf[k] = 8'h00;
        load_cnt = 0;
        paths_sent++;
    endfunction

    // Send one byte transfer
    task automatic send_byte(logic [7:0] b, logic last, logic keep);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_path_byte = b;
        s_path_last = last;
        s_keep_last_element = keep;
        predict_byte(b, last, keep);
        bytes_sent++;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Send a byte list, the final one marked last
    task automatic send_path(logic [7:0] bl[$], logic keep);
        foreach (bl[i]) send_byte(bl[i], i == bl.size() - 1, keep);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0) @(negedge aclk);
    endtask

    // Sink side backpressure
    always @(negedge aclk) m_ready <= ($urandom_range(99) >= snk_idle_pct);

    // Result checker
    always @(posedge aclk) begin
        out_beat_t e;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected transfer byte=%h last=%b status=%b",
                         $time, m_out_byte, m_out_last, m_status);
                errors++;
            end else begin
                e = pending_beats.pop_front();
                if (m_out_byte !== e.data) begin
                    $display("%0t: out_byte exp %h got %h", $time, e.data, m_out_byte);
                    errors++;
                end
                if (m_out_last !== e.last) begin
                    $display("%0t: out_last exp %b got %b", $time, e.last, m_out_last);
                    errors++;
                end
                if (m_status !== e.status) begin
                    $display("%0t: status exp %b got %b", $time, e.status, m_status);
                    errors++;
                end
            end
        end
    end

    // Timeout
    always @(posedge aclk) begin
        if (cycles > CYC_LIMIT) begin
            $display("timeout at cycle %0d", cycles);
            $display("** activity_path_reencoder: FAILED **");
            $finish;
        end
    end

    // Build a well-formed path from random elements, then maybe damage it
    function automatic void make_path(output logic [7:0] bl[$]);
        int cnt;
        int pos;
        logic [31:0] v;
        foreach (enc_buf[k]) enc_buf[k] = 8'h00;
        cnt = $urandom_range(0, 12);
        pos = 0;
        for (int i = 0; i < cnt; i++) begin
            case ($urandom_range(5))
                0, 1: v = $urandom_range(1, 10);
                2: v = $urandom_range(11, 255);
                3: v = $urandom_range(256, 4095);
                4: v = $urandom_range(4096, 32'hFFFFFF);
                default: v = $urandom;
            endcase
            pos = pack_element(pos, v);
        end
        bl = {};
        foreach (enc_buf[k]) bl.push_back(enc_buf[k]);
        case ($urandom_range(9))
            0: bl[$urandom_range(11)] = 8'($urandom);
            1: bl[$urandom_range(11)] = {apr_pkg::CODE_PREFIX, 4'($urandom)};
            2: bl[$urandom_range(11)] = {4'($urandom), apr_pkg::CODE_PREFIX};
            default: ;
        endcase
    endfunction

    task automatic test_directed();
        // immediates, keep whole path (full length first after reset)
        send_path('{8'h12, 8'h34, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'hFF}, 1'b1);
        // multi-byte codes in high nibble with low nibble, drop last
        send_path('{8'hC1, 8'h23, 8'hD0, 8'h34, 8'h12, 8'hE0, 8'h01, 8'h02,
                    8'h03, 8'h00, 8'h00, 8'h00}, 1'b0);
        // prefix codes, both nibble positions
        send_path('{8'hBC, 8'h7F, 8'h1B, 8'hF0, 8'hAA, 8'hBB, 8'hCC, 8'hDD,
                    8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
        // undefined prefix
        send_path('{8'h1B, 8'h50}, 1'b1);
        // stray zero after a mid-sized value
        send_path('{8'hC1, 8'h23, 8'h00, 8'h45, 8'h00}, 1'b1);
        // truncated value near the end
        send_path('{8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11,
                    8'h11, 8'h11, 8'hF0, 8'h01}, 1'b1);
        // prefix in low nibble of the final byte
        send_path('{8'h23, 8'h45, 8'h67, 8'h89, 8'h12, 8'h34, 8'h56, 8'h78,
                    8'h9A, 8'h12, 8'h34, 8'h1B}, 1'b1);
        // element limit: every nibble an immediate
        send_path('{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88,
                    8'h99, 8'hAA, 8'h12, 8'h34}, 1'b1);
        // wide value, upper bits lost
        send_path('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1);
        // empty path with drop
        send_path('{8'h00}, 1'b0);
        // too many bytes before the last mark
        send_path('{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'h12, 8'h34, 8'h56,
                    8'h78, 8'h9A, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A}, 1'b1);
        // two four-byte values, then a value truncated at the end of the path
        send_path('{8'hF0, 8'h11, 8'h22, 8'h33, 8'h44, 8'hF0, 8'h55, 8'h66,
                    8'h77, 8'h88, 8'hD0, 8'hFF}, 1'b1);
        wait_drained();
    endtask

    task automatic test_random(int src_pct, int snk_pct, int n_bytes);
        logic [7:0] bl[$];
        int stop_at;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            case ($urandom_range(9))
                0: begin
                    // noise, possibly short or overlong
                    bl = {};
                    repeat ($urandom_range(1, 15)) bl.push_back(8'($urandom));
                end
                default: make_path(bl);
            endcase
            send_path(bl, 1'($urandom_range(1)));
            // hold off until the block has drained
            if ($urandom_range(7) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_path_byte = 8'h00;
        s_path_last = 1'b0;
        s_keep_last_element = 1'b0;
        m_ready = 1'b0;
        errors = 0; paths_sent = 0; bytes_sent = 0; err_paths = 0;
        beats_seen = 0; cycles = 0; load_cnt = 0;
        src_idle_pct = 26; snk_idle_pct = 69;
        foreach (load_buf[k]) load_buf[k] = 8'h00;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random(26, 69, 20);
        test_random(69, 26, 20);
        test_random(0, 0, 20);

        repeat (80) @(posedge aclk);
        $display("covered %0d paths from %0d byte transfers, %0d with undefined prefix",
                 paths_sent, bytes_sent, err_paths);
        $display("%0d result transfers checked, %0d mismatches", beats_seen, errors);
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("** activity_path_reencoder: PASSED **");
        end else begin
            $display("** activity_path_reencoder: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/apr_pkg.sv
rtl/apr_front.sv
rtl/apr_queue.sv
rtl/apr_back.sv
rtl/activity_path_reencoder.sv
sim/tb_activity_path_reencoder.sv
